// ===== rtl/djarith_pkg.sv =====
`default_nettype none

package djarith_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int JDN_W   = 22;
  localparam int OFF_W   = 22;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_YEAR = 2'd0,
    CFG_MAX_YEAR = 2'd1
  } cfg_idx_t;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1900;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2100;

  localparam int NUM_STAGES = 10;
  localparam int ST_IN  = 0;
  localparam int ST_F1  = 1;
  localparam int ST_F2  = 2;
  localparam int ST_R1  = 3;
  localparam int ST_R2  = 4;
  localparam int ST_R3  = 5;
  localparam int ST_R4  = 6;
  localparam int ST_R5  = 7;
  localparam int ST_R6  = 8;
  localparam int ST_OUT = 9;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  localparam int EPOCH_YEAR    = 4800;
  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  localparam int JDN_BIAS      = 32045;
  localparam int JDN_SHIFT     = 32044;

  localparam int RECIP25_S = 16;
  localparam int RECIP25_K = ((1 << RECIP25_S) + 24) / 25;

  localparam int DIV1_D = 146097;
  localparam int DIV1_S = 25;
  localparam int DIV1_K = (1 << DIV1_S) / DIV1_D;

  localparam int DIV2_D = 1461;
  localparam int DIV2_S = 18;
  localparam int DIV2_K = (1 << DIV2_S) / DIV2_D;

  localparam int DIV3_D = 153;
  localparam int DIV3_S = 11;
  localparam int DIV3_K = (1 << DIV3_S) / DIV3_D;

  localparam int RECIP5_S = 10;
  localparam int RECIP5_K = ((1 << RECIP5_S) + 4) / 5;

  typedef struct packed {
    logic              valid_a;
    logic              valid_b;
    logic [JDN_W-1:0]  day_number_a;
    logic [JDN_W-1:0]  days_apart;
    logic              a_before_b;
    logic              a_equals_b;
  } cmp_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // days from March 1 to the first of the month, month counted from March
  function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] mm);
    logic [8:0] n;
    unique case (mm)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd61;
      4'd3:    n = 9'd92;
      4'd4:    n = 9'd122;
      4'd5:    n = 9'd153;
      4'd6:    n = 9'd184;
      4'd7:    n = 9'd214;
      4'd8:    n = 9'd245;
      4'd9:    n = 9'd275;
      4'd10:   n = 9'd306;
      4'd11:   n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/djarith_pipe_ctl.sv =====
`default_nettype none

module djarith_pipe_ctl
  import djarith_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output stage_en_t en
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = {vld_r[NUM_STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_ready  = en[ST_IN];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/djarith_to_jdn.sv =====
`default_nettype none

module djarith_to_jdn
  import djarith_pkg::*;
(
  input  wire logic               clk,
  input  wire stage_en_t          en,
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [YEAR_W-1:0]  year,
  input  wire logic [YEAR_W-1:0]  min_year,
  input  wire logic [YEAR_W-1:0]  max_year,
  output logic                    date_valid,
  output logic [JDN_W-1:0]        jdn
);

  logic               early;
  logic [13:0]        yy_nxt;
  logic [MONTH_W-1:0] mm_nxt;
  logic [21:0]        p365_nxt;
  logic [6:0]         q100_nxt;
  logic [4:0]         q400_nxt;
  logic [5:0]         cent_nxt;

  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [13:0]        yy_r;
  logic               range_ok_r;
  logic               month_ok_r;
  logic [8:0]         mbase_r;
  logic [21:0]        p365_r;
  logic [6:0]         q100_r;
  logic [4:0]         q400_r;
  logic [5:0]         cent_r;

  logic               div100;
  logic               leap;
  logic [DAY_W-1:0]   lim;
  logic               valid_nxt;
  logic [22:0]        sum;
  logic [JDN_W-1:0]   jdn_nxt;
  logic               valid_r;
  logic [JDN_W-1:0]   jdn_r;

  always_comb begin
    early    = month <= 4'd2;
    yy_nxt   = 14'(year) + 14'(EPOCH_YEAR) - 14'(early);
    mm_nxt   = early ? month + 4'd9 : month - 4'd3;
    p365_nxt = 22'(23'(yy_nxt) * 23'(DAYS_PER_YEAR));
    q100_nxt = 7'((24'(yy_nxt[13:2]) * 24'(RECIP25_K)) >> RECIP25_S);
    q400_nxt = 5'((24'(yy_nxt[13:4]) * 24'(RECIP25_K)) >> RECIP25_S);
    cent_nxt = 6'((24'(year[11:2]) * 24'(RECIP25_K)) >> RECIP25_S);
  end

  always_ff @(posedge clk) begin
    if (en[ST_F1]) begin
      day_r      <= day;
      month_r    <= month;
      year_r     <= year;
      yy_r       <= yy_nxt;
      range_ok_r <= (year >= min_year) && (year <= max_year);
      month_ok_r <= (month >= 4'd1) && (month <= 4'd12);
      mbase_r    <= month_base(mm_nxt);
      p365_r     <= p365_nxt;
      q100_r     <= q100_nxt;
      q400_r     <= q400_nxt;
      cent_r     <= cent_nxt;
    end
  end

  always_comb begin
    div100    = (12'(cent_r) * 12'(CENTURY)) == year_r;
    leap      = (year_r[1:0] == 2'd0) && (!div100 || (cent_r[1:0] == 2'd0));
    lim       = month_days(month_r, leap);
    valid_nxt = range_ok_r && month_ok_r && (day_r != 5'd0) && (day_r <= lim);
    sum       = 23'(day_r) + 23'(mbase_r) + 23'(p365_r) + 23'(yy_r[13:2])
              + 23'(q400_r) - 23'(q100_r) - 23'(JDN_BIAS);
    jdn_nxt   = valid_nxt ? sum[JDN_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_F2]) begin
      valid_r <= valid_nxt;
      jdn_r   <= jdn_nxt;
    end
  end

  assign date_valid = valid_r;
  assign jdn        = jdn_r;

endmodule

`default_nettype wire

// ===== rtl/djarith_from_jdn.sv =====
`default_nettype none

module djarith_from_jdn
  import djarith_pkg::*;
(
  input  wire logic                clk,
  input  wire stage_en_t           en,
  input  wire logic                ok_in,
  input  wire logic signed [23:0]  jdn,
  input  wire logic [YEAR_W-1:0]   min_year,
  input  wire logic [YEAR_W-1:0]   max_year,
  output logic [DAY_W-1:0]         sum_day,
  output logic [MONTH_W-1:0]       sum_month,
  output logic [YEAR_W-1:0]        sum_year,
  output logic                     sum_valid
);

  // 400-year cycles
  logic [22:0] a1;
  logic [24:0] t1_nxt;
  logic [32:0] prod3;
  logic        ok3_r;
  logic [24:0] t1_r;
  logic [7:0]  q1_r;

  logic [25:0] prod4;
  logic [24:0] diff4;
  logic [18:0] rem4;
  logic        ge4;
  logic [18:0] fix4;
  logic        ok4_r;
  logic [7:0]  b4_r;
  logic [15:0] c4_r;

  // 4-year cycles
  logic [17:0] t2_nxt;
  logic [25:0] prod5;
  logic        ok5_r;
  logic [7:0]  b5_r;
  logic [17:0] t2_r;
  logic [7:0]  q2_r;

  logic [18:0] prod6;
  logic [17:0] diff6;
  logic [11:0] rem6;
  logic        ge6;
  logic [11:0] fix6;
  logic        ok6_r;
  logic [7:0]  b6_r;
  logic [7:0]  dq6_r;
  logic [8:0]  e6_r;

  // month within the March-based year
  logic [10:0] t3_nxt;
  logic [14:0] prod7;
  logic        ok7_r;
  logic [7:0]  b7_r;
  logic [7:0]  dq7_r;
  logic [10:0] t3_r;
  logic [3:0]  q3_r;

  logic [11:0] prod8;
  logic [10:0] diff8;
  logic [8:0]  rem8;
  logic        ge8;
  logic [8:0]  fix8;
  logic        ok8_r;
  logic [7:0]  b8_r;
  logic [7:0]  dq8_r;
  logic [3:0]  m8_r;
  logic [7:0]  r8_r;

  logic               dec;
  logic [DAY_W-1:0]   rd;
  logic [MONTH_W-1:0] rm;
  logic [15:0]        ry_u;
  logic signed [15:0] ry;
  logic               in_range;

  always_comb begin
    a1     = jdn[22:0] + 23'(JDN_SHIFT);
    t1_nxt = {a1, 2'b11};
    prod3  = 33'(t1_nxt) * 33'(DIV1_K);
  end

  always_ff @(posedge clk) begin
    if (en[ST_R1]) begin
      ok3_r <= ok_in && !jdn[23];
      t1_r  <= t1_nxt;
      q1_r  <= prod3[DIV1_S +: 8];
    end
  end

  always_comb begin
    prod4 = 26'(q1_r) * 26'(DIV1_D);
    diff4 = t1_r - prod4[24:0];
    rem4  = diff4[18:0];
    ge4   = rem4 >= 19'(DIV1_D);
    fix4  = ge4 ? rem4 - 19'(DIV1_D) : rem4;
  end

  always_ff @(posedge clk) begin
    if (en[ST_R2]) begin
      ok4_r <= ok3_r;
      b4_r  <= q1_r + 8'(ge4);
      c4_r  <= fix4[17:2];
    end
  end

  always_comb begin
    t2_nxt = {c4_r, 2'b11};
    prod5  = 26'(t2_nxt) * 26'(DIV2_K);
  end

  always_ff @(posedge clk) begin
    if (en[ST_R3]) begin
      ok5_r <= ok4_r;
      b5_r  <= b4_r;
      t2_r  <= t2_nxt;
      q2_r  <= prod5[DIV2_S +: 8];
    end
  end

  always_comb begin
    prod6 = 19'(q2_r) * 19'(DIV2_D);
    diff6 = t2_r - prod6[17:0];
    rem6  = diff6[11:0];
    ge6   = rem6 >= 12'(DIV2_D);
    fix6  = ge6 ? rem6 - 12'(DIV2_D) : rem6;
  end

  always_ff @(posedge clk) begin
    if (en[ST_R4]) begin
      ok6_r <= ok5_r;
      b6_r  <= b5_r;
      dq6_r <= q2_r + 8'(ge6);
      e6_r  <= fix6[10:2];
    end
  end

  always_comb begin
    t3_nxt = {e6_r, 2'b00} + 11'(e6_r) + 11'd2;
    prod7  = 15'(t3_nxt) * 15'(DIV3_K);
  end

  always_ff @(posedge clk) begin
    if (en[ST_R5]) begin
      ok7_r <= ok6_r;
      b7_r  <= b6_r;
      dq7_r <= dq6_r;
      t3_r  <= t3_nxt;
      q3_r  <= prod7[DIV3_S +: 4];
    end
  end

  always_comb begin
    prod8 = 12'(q3_r) * 12'(DIV3_D);
    diff8 = t3_r - prod8[10:0];
    rem8  = diff8[8:0];
    ge8   = rem8 >= 9'(DIV3_D);
    fix8  = ge8 ? rem8 - 9'(DIV3_D) : rem8;
  end

  always_ff @(posedge clk) begin
    if (en[ST_R6]) begin
      ok8_r <= ok7_r;
      b8_r  <= b7_r;
      dq8_r <= dq7_r;
      m8_r  <= q3_r + 4'(ge8);
      r8_r  <= fix8[7:0];
    end
  end

  always_comb begin
    dec      = m8_r >= 4'd10;
    rd       = 5'((16'(r8_r) * 16'(RECIP5_K)) >> RECIP5_S) + 5'd1;
    rm       = dec ? m8_r - 4'd9 : m8_r + 4'd3;
    ry_u     = 16'(b8_r) * 16'(CENTURY) + 16'(dq8_r) + 16'(dec);
    ry       = $signed(ry_u) - 16'sd4800;
    in_range = !ry[15] && (ry[14:0] >= 15'(min_year)) && (ry[14:0] <= 15'(max_year));
    sum_valid = ok8_r && in_range;
    sum_day   = sum_valid ? rd : '0;
    sum_month = sum_valid ? rm : '0;
    sum_year  = sum_valid ? ry[YEAR_W-1:0] : '0;
  end

endmodule

`default_nettype wire

// ===== rtl/date_julian_arithmetic.sv =====
// Gregorian date arithmetic on Julian day numbers. Each request carries two
// dates and a signed day offset; the block checks both dates against the
// configured year range and the calendar (leap years included), returns the
// day number of the first date, the signed day count to the second date with
// before and equal flags, and the first date moved by the offset, flagged
// invalid when the first date is invalid or the sum is before day zero or
// outside the year range. A request is accepted every cycle unless the
// output stalls; the ten-stage pipeline is set by the reciprocal divisions
// (400-year cycle, 4-year cycle, month) turning the shifted day number into
// a date, each an estimate and a remainder-correction stage. Stages stall
// independently, so bubbles close up while the output waits. Year limits
// are written through the cfg port (index 0 minimum, 1 maximum) while idle.
`default_nettype none

module date_julian_arithmetic
  import djarith_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // day_a[4:0], month_a[8:5], year_a[20:9], day_b[25:21], month_b[29:26],
  // year_b[41:30], day_offset[63:42]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // day_number_a[21:0], days_apart[43:22], a_before_b[44], a_equals_b[45],
  // sum_day[50:46], sum_month[54:51], sum_year[66:55], zero[71:67]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // valid_a[0], valid_b[1], sum_valid[2]
  output logic [OUT_TUSER_W-1:0]      out_tuser,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [YEAR_W-1:0]      cfg_data
);

  stage_en_t en;

  logic [YEAR_W-1:0] min_year_r;
  logic [YEAR_W-1:0] max_year_r;

  logic [DAY_W-1:0]   day_a_r;
  logic [MONTH_W-1:0] month_a_r;
  logic [YEAR_W-1:0]  year_a_r;
  logic [DAY_W-1:0]   day_b_r;
  logic [MONTH_W-1:0] month_b_r;
  logic [YEAR_W-1:0]  year_b_r;
  logic [OFF_W-1:0]   off0_r;
  logic [OFF_W-1:0]   off1_r;
  logic [OFF_W-1:0]   off2_r;

  logic               valid_a;
  logic               valid_b;
  logic [JDN_W-1:0]   jdn_a;
  logic [JDN_W-1:0]   jdn_b;
  logic signed [23:0] j_sum;
  cmp_t               cmp_nxt;
  cmp_t               cmp_r [ST_R1:ST_R6];

  logic [DAY_W-1:0]   sum_day;
  logic [MONTH_W-1:0] sum_month;
  logic [YEAR_W-1:0]  sum_year;
  logic               sum_valid;

  logic [OUT_TDATA_W-1:0] tdata_nxt;
  logic [OUT_TUSER_W-1:0] tuser_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_YEAR: min_year_r <= cfg_data;
        CFG_MAX_YEAR: max_year_r <= cfg_data;
        default: ;
      endcase
    end
  end

  djarith_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .en        (en)
  );

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      day_a_r   <= in_tdata[4:0];
      month_a_r <= in_tdata[8:5];
      year_a_r  <= in_tdata[20:9];
      day_b_r   <= in_tdata[25:21];
      month_b_r <= in_tdata[29:26];
      year_b_r  <= in_tdata[41:30];
      off0_r    <= in_tdata[63:42];
    end
    if (en[ST_F1]) begin
      off1_r <= off0_r;
    end
    if (en[ST_F2]) begin
      off2_r <= off1_r;
    end
  end

  djarith_to_jdn u_jdn_a (
    .clk        (clk),
    .en         (en),
    .day        (day_a_r),
    .month      (month_a_r),
    .year       (year_a_r),
    .min_year   (min_year_r),
    .max_year   (max_year_r),
    .date_valid (valid_a),
    .jdn        (jdn_a)
  );

  djarith_to_jdn u_jdn_b (
    .clk        (clk),
    .en         (en),
    .day        (day_b_r),
    .month      (month_b_r),
    .year       (year_b_r),
    .min_year   (min_year_r),
    .max_year   (max_year_r),
    .date_valid (valid_b),
    .jdn        (jdn_b)
  );

  always_comb begin
    j_sum = $signed({2'b00, jdn_a}) + $signed({{2{off2_r[OFF_W-1]}}, off2_r});
    cmp_nxt.valid_a      = valid_a;
    cmp_nxt.valid_b      = valid_b;
    cmp_nxt.day_number_a = jdn_a;
    cmp_nxt.days_apart   = (valid_a && valid_b) ? jdn_b - jdn_a : '0;
    cmp_nxt.a_before_b   = valid_a && valid_b && (jdn_a < jdn_b);
    cmp_nxt.a_equals_b   = valid_a && valid_b && (jdn_a == jdn_b);
  end

  always_ff @(posedge clk) begin
    if (en[ST_R1]) begin
      cmp_r[ST_R1] <= cmp_nxt;
    end
    for (int k = ST_R2; k <= ST_R6; k++) begin
      if (en[k]) begin
        cmp_r[k] <= cmp_r[k-1];
      end
    end
  end

  djarith_from_jdn u_from_jdn (
    .clk       (clk),
    .en        (en),
    .ok_in     (valid_a),
    .jdn       (j_sum),
    .min_year  (min_year_r),
    .max_year  (max_year_r),
    .sum_day   (sum_day),
    .sum_month (sum_month),
    .sum_year  (sum_year),
    .sum_valid (sum_valid)
  );

  always_comb begin
    tdata_nxt = {5'd0, sum_year, sum_month, sum_day,
                 cmp_r[ST_R6].a_equals_b, cmp_r[ST_R6].a_before_b,
                 cmp_r[ST_R6].days_apart, cmp_r[ST_R6].day_number_a};
    tuser_nxt = {sum_valid, cmp_r[ST_R6].valid_b, cmp_r[ST_R6].valid_a};
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= tuser_nxt;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

`default_nettype wire

// ===== test/julian_day_checker.sv =====
module julian_day_checker
  import djarith_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // day_a, month_a, year_a, day_b, month_b, year_b, day_offset
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // day_number_a, days_apart, a_before_b, a_equals_b, sum_day, sum_month, sum_year
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  // valid_a, valid_b, sum_valid
  input  wire logic [OUT_TUSER_W-1:0] out_tuser,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [YEAR_W-1:0]      cfg_data,
  input  wire logic                   drained,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              valid_a;
    logic              valid_b;
    logic [JDN_W-1:0]  day_number_a;
    logic [JDN_W-1:0]  days_apart;
    logic              a_before_b;
    logic              a_equals_b;
    logic [DAY_W-1:0]  sum_day;
    logic [MONTH_W-1:0] sum_month;
    logic [YEAR_W-1:0] sum_year;
    logic              sum_valid;
  } calendar_result_t;

  logic [YEAR_W-1:0] min_year_r;
  logic [YEAR_W-1:0] max_year_r;
  calendar_result_t  expected_dates_q[$];
  calendar_result_t  want;
  calendar_result_t  got;
  int                result_idx;
  logic              leftover_checked;

  function automatic logic date_in_range(longint d, longint m, longint y);
    longint lim;
    logic   leap;
    if (y < min_year_r || y > max_year_r) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      4, 6, 9, 11: lim = 30;
      2:           lim = leap ? 29 : 28;
      default:     lim = 31;
    endcase
    return d >= 1 && d <= lim;
  endfunction

  function automatic longint day_number(longint d, longint m, longint y);
    longint a;
    longint yy;
    longint mm;
    a  = (14 - m) / 12;
    yy = y + EPOCH_YEAR - a;
    mm = m + 12 * a - 3;
    return d + (153 * mm + 2) / 5 + DAYS_PER_YEAR * yy + yy / 4 - yy / 100 + yy / 400
           - JDN_BIAS;
  endfunction

  function automatic calendar_result_t predict_calendar(logic [IN_TDATA_W-1:0] req);
    calendar_result_t    r;
    logic signed [OFF_W-1:0] off;
    longint da, ma, ya, db, mb, yb;
    longint ja, jb, diff, j, a, b, c, d, e, m, rd, rm, ry;
    da  = req[4:0];
    ma  = req[8:5];
    ya  = req[20:9];
    db  = req[25:21];
    mb  = req[29:26];
    yb  = req[41:30];
    off = req[63:42];
    r.valid_a = date_in_range(da, ma, ya);
    r.valid_b = date_in_range(db, mb, yb);
    ja = r.valid_a ? day_number(da, ma, ya) : 0;
    jb = r.valid_b ? day_number(db, mb, yb) : 0;
    diff = (r.valid_a && r.valid_b) ? jb - ja : 0;
    r.day_number_a = ja[JDN_W-1:0];
    r.days_apart   = diff[JDN_W-1:0];
    r.a_before_b   = r.valid_a && r.valid_b && (ja < jb);
    r.a_equals_b   = r.valid_a && r.valid_b && (ja == jb);
    r.sum_day   = '0;
    r.sum_month = '0;
    r.sum_year  = '0;
    r.sum_valid = 1'b0;
    j = ja + off;
    if (r.valid_a && j >= 0) begin
      a  = j + JDN_SHIFT;
      b  = (4 * a + 3) / DIV1_D;
      c  = a - (DIV1_D * b) / 4;
      d  = (4 * c + 3) / DIV2_D;
      e  = c - (DIV2_D * d) / 4;
      m  = (5 * e + 2) / DIV3_D;
      rd = e - (DIV3_D * m + 2) / 5 + 1;
      rm = m + 3 - 12 * (m / 10);
      ry = CENTURY * b + d - EPOCH_YEAR + m / 10;
      if (ry >= min_year_r && ry <= max_year_r) begin
        r.sum_day   = rd[DAY_W-1:0];
        r.sum_month = rm[MONTH_W-1:0];
        r.sum_year  = ry[YEAR_W-1:0];
        r.sum_valid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report(string msg);
    $display("[%0t] result %0d: %s", $realtime, result_idx, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      min_year_r = MIN_YEAR_RST;
      max_year_r = MAX_YEAR_RST;
      expected_dates_q.delete();
      mismatches = 0;
      result_idx = 0;
      leftover_checked = 1'b0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_YEAR: min_year_r = cfg_data;
          CFG_MAX_YEAR: max_year_r = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_dates_q.push_back(predict_calendar(in_tdata));
      if (out_tvalid && out_tready) begin
        got.day_number_a = out_tdata[21:0];
        got.days_apart   = out_tdata[43:22];
        got.a_before_b   = out_tdata[44];
        got.a_equals_b   = out_tdata[45];
        got.sum_day      = out_tdata[50:46];
        got.sum_month    = out_tdata[54:51];
        got.sum_year     = out_tdata[66:55];
        got.valid_a      = out_tuser[0];
        got.valid_b      = out_tuser[1];
        got.sum_valid    = out_tuser[2];
        if (expected_dates_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = expected_dates_q.pop_front();
          if (got.valid_a !== want.valid_a)
            report($sformatf("valid_a exp %0d got %0d", want.valid_a, got.valid_a));
          if (got.valid_b !== want.valid_b)
            report($sformatf("valid_b exp %0d got %0d", want.valid_b, got.valid_b));
          if (got.day_number_a !== want.day_number_a)
            report($sformatf("day_number_a exp %0d got %0d", want.day_number_a,
                             got.day_number_a));
          if (got.days_apart !== want.days_apart)
            report($sformatf("days_apart exp %0d got %0d", $signed(want.days_apart),
                             $signed(got.days_apart)));
          if (got.a_before_b !== want.a_before_b)
            report($sformatf("a_before_b exp %0d got %0d", want.a_before_b, got.a_before_b));
          if (got.a_equals_b !== want.a_equals_b)
            report($sformatf("a_equals_b exp %0d got %0d", want.a_equals_b, got.a_equals_b));
          if (got.sum_day !== want.sum_day)
            report($sformatf("sum_day exp %0d got %0d", want.sum_day, got.sum_day));
          if (got.sum_month !== want.sum_month)
            report($sformatf("sum_month exp %0d got %0d", want.sum_month, got.sum_month));
          if (got.sum_year !== want.sum_year)
            report($sformatf("sum_year exp %0d got %0d", want.sum_year, got.sum_year));
          if (got.sum_valid !== want.sum_valid)
            report($sformatf("sum_valid exp %0d got %0d", want.sum_valid, got.sum_valid));
        end
        result_idx++;
      end
      if (drained && !leftover_checked) begin
        if (expected_dates_q.size() != 0)
          report($sformatf("%0d results never arrived", expected_dates_q.size()));
        leftover_checked = 1'b1;
      end
      outstanding <= expected_dates_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import djarith_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 245;
  localparam int NUM_PHASES  = 8;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_MIN_YEAR;
  logic [YEAR_W-1:0]      cfg_data = '0;
  logic                   drained = 1'b0;
  int                     mismatches;
  int                     outstanding;

  int                     burst_left = 0;
  int                     idle_cycles = 0;
  logic [YEAR_W-1:0]      lo_year = MIN_YEAR_RST;
  logic [YEAR_W-1:0]      hi_year = MAX_YEAR_RST;

  always #5 clk = ~clk;

  date_julian_arithmetic dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  julian_day_checker julian_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .drained     (drained),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: segments of differing patterns, with a long hold now and then
  initial begin
    int seg;
    int mode;
    int span;
    seg = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (seg % 6 == 1) begin
        out_tready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        mode = $urandom_range(3, 0);
        span = $urandom_range(200, 20);
        for (int i = 0; i < span; i++) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= $urandom_range(1, 0);
            2:       out_tready <= ($urandom_range(9, 0) != 0);
            default: out_tready <= (i % 4 != 3);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  task automatic send_dates(input logic [DAY_W-1:0] da, input logic [MONTH_W-1:0] ma,
                            input logic [YEAR_W-1:0] ya, input logic [DAY_W-1:0] db,
                            input logic [MONTH_W-1:0] mb, input logic [YEAR_W-1:0] yb,
                            input logic [OFF_W-1:0] off);
    int gap;
    in_tdata  <= {off, yb, mb, db, ya, ma, da};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_year_range(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
    if ($urandom_range(1, 0)) write_reg(CFG_SPARE_A + $urandom_range(1, 0), $urandom);
    write_reg(CFG_MIN_YEAR, lo);
    write_reg(CFG_MAX_YEAR, hi);
    lo_year = lo;
    hi_year = hi;
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    int roll;
    roll = $urandom_range(99, 0);
    if (lo_year <= hi_year && roll < 85) return $urandom_range(hi_year, lo_year);
    case (roll % 4)
      0:       return lo_year - 1;
      1:       return hi_year + 1;
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] pick_day();
    int roll;
    roll = $urandom_range(9, 0);
    if (roll < 7) return $urandom_range(28, 1);
    if (roll < 9) return $urandom_range(31, 29);
    return $urandom_range(31, 0);
  endfunction

  function automatic logic [MONTH_W-1:0] pick_month();
    return ($urandom_range(9, 0) != 0) ? $urandom_range(12, 1) : $urandom_range(15, 0);
  endfunction

  task automatic send_random();
    logic [DAY_W-1:0]   da, db;
    logic [MONTH_W-1:0] ma, mb;
    logic [YEAR_W-1:0]  ya, yb;
    logic [OFF_W-1:0]   off;
    int                 roll;
    da = pick_day();
    ma = pick_month();
    ya = pick_year();
    roll = $urandom_range(3, 0);
    if (roll == 0) begin
      db = da; mb = ma; yb = ya;
    end else if (roll == 1) begin
      db = pick_day(); mb = ma; yb = ya + $urandom_range(2, 0) - 1;
    end else begin
      db = pick_day(); mb = pick_month(); yb = pick_year();
    end
    case ($urandom_range(9, 0))
      0, 1, 2, 3: off = int'($urandom_range(1000, 0)) - 500;
      4, 5, 6:    off = int'($urandom_range(400000, 0)) - 200000;
      7, 8:       off = $urandom;
      default:    off = $urandom_range(1, 0) ? 22'h1FFFFF : 22'h200000;
    endcase
    send_dates(da, ma, ya, db, mb, yb, off);
  endtask

  initial begin
    int lo_tab[6];
    int hi_tab[6];
    lo_tab = '{1900, 0, 1583, 2024, 3000, 0};
    hi_tab = '{2100, 4095, 2999, 2024, 1000, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset range
    send_dates(29, 2, 2000, 1, 3, 2000, 0);
    send_dates(29, 2, 1900, 1, 1, 1900, 0);
    send_dates(28, 2, 2100, 1, 1, 1900, 1);
    send_dates(1, 1, 1900, 31, 12, 2100, -1);
    send_dates(31, 12, 2100, 1, 1, 1900, 1);
    send_dates(4, 7, 2024, 4, 7, 2024, 0);
    send_dates(0, 7, 2024, 4, 7, 2024, 5);
    send_dates(31, 4, 2024, 1, 5, 2024, 0);
    send_dates(1, 0, 2024, 1, 1, 2024, 0);
    send_dates(1, 13, 2024, 1, 1, 2024, 0);
    send_dates(1, 15, 2024, 1, 1, 2024, 0);
    send_dates(31, 12, 2099, 0, 1, 2000, 366);
    send_dates(31, 1, 2000, 1, 2, 2000, 30);
    send_dates(1, 1, 2000, 1, 1, 2001, 2097151);
    send_dates(1, 1, 1900, 2, 1, 1900, -2097152);
    send_dates(15, 6, 0, 15, 6, 4095, 0);
    send_dates(29, 2, 2024, 28, 2, 2023, 365);
    wait_idle();

    set_year_range(0, 4095);
    send_dates(1, 1, 0, 31, 12, 4095, 0);
    send_dates(1, 3, 0, 1, 1, 0, -2097152);
    send_dates(31, 12, 4095, 1, 1, 0, 2097151);
    send_dates(29, 2, 0, 1, 3, 0, -60);
    send_dates(31, 12, 4095, 31, 12, 4095, 0);
    wait_idle();

    set_year_range(2100, 1900);
    send_dates(1, 1, 2000, 1, 1, 2000, 0);
    wait_idle();

    write_reg(CFG_SPARE_A, 0);
    write_reg(CFG_SPARE_B, 4095);
    set_year_range(2024, 2024);
    send_dates(1, 1, 2024, 31, 12, 2024, 365);
    send_dates(31, 12, 2024, 1, 1, 2024, 1);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 6)
        set_year_range(lo_tab[p], hi_tab[p]);
      else
        set_year_range($urandom_range(3000, 0), $urandom_range(4095, 1000));
      repeat (PHASE_ITEMS) send_random();
      wait_idle();
    end

    repeat (30) @(posedge clk);
    drained <= 1'b1;
    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
